>>> design/gbm_pkg.sv
// Shared types and constants for the Goertzel bin magnitude core.
package gbm_pkg;

	// multiplier digit and fixed accumulator widths
	localparam int DIGIT_W = 32;
	localparam int ACC_W = 48;
	// c*s1 magnitude clamp point and the widths of the recursion sum
	localparam int PROD_CLAMP_LOG2 = 50;
	localparam int M_W = PROD_CLAMP_LOG2 + 1;
	localparam int S_W = M_W + 2;
	// square root: root bits, radicand bits, remainder bits
	localparam int RW = ACC_W + 1;
	localparam int TW = 2 * ACC_W + 2;
	localparam int REM_W = RW + 3;
	localparam int STEP_W = $clog2(RW);

	// last step of each product phase in the amplitude program
	localparam logic [STEP_W-1:0] STEP_T_LAST = STEP_W'(3);
	localparam logic [STEP_W-1:0] STEP_SQ_LAST = STEP_W'(11);
	localparam logic [STEP_W-1:0] STEP_CR_LAST = STEP_W'(14);

	// register index decoded from paddr[2]
	localparam logic REG_TWO_COS_COEF = 1'b0;

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b0000_0000_0001,
		ST_MUL0  = 12'b0000_0000_0010,
		ST_MUL1  = 12'b0000_0000_0100,
		ST_DRAIN = 12'b0000_0000_1000,
		ST_UPD   = 12'b0000_0001_0000,
		ST_AMUL  = 12'b0000_0010_0000,
		ST_TCPY  = 12'b0000_0100_0000,
		ST_SHIFT = 12'b0000_1000_0000,
		ST_QFIN  = 12'b0001_0000_0000,
		ST_SQRT  = 12'b0010_0000_0000,
		ST_DIV   = 12'b0100_0000_0000,
		ST_FIN   = 12'b1000_0000_0000
	} state_t;

	// control that travels with a registered partial product
	typedef struct packed {
		logic       valid;
		logic [1:0] shift;
		logic       sub;
	} mac_ctl_t;

endpackage

>>> design/gbm_ifs.sv
// Valid/ready channel interfaces for samples and bin results.
interface gbm_sample_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          last_sample;

	modport source(output valid, output sample, output last_sample, input ready);
	modport sink(input valid, input sample, input last_sample, output ready);
endinterface

interface gbm_result_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] bin_amplitude;
	logic                   saturated;

	modport source(output valid, output bin_amplitude, output saturated, input ready);
	modport sink(input valid, input bin_amplitude, input saturated, output ready);
endinterface

>>> design/goertzel_bin_magnitude_core.sv
// Goertzel single-bin detector: recursion, exact energy, square root and divide.
// Per sample: two 32x32 partial products of c*s1, a drain state, and an
// update state in which the next sample beat is taken.
// After a last sample: energy products, restoring square root, restoring
// divide by the sample count, then the result goes to the output slot.
// arst_n clears s1, s2, the count, the clip flag, the coefficient and the
// output slot at once; there is no clearing pass.
module goertzel_bin_magnitude_core #(
	parameter int MAX_BLOCK_LEN = 65536,
	parameter int SAMPLE_BITS = 16,
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	gbm_sample_if.sink  samples,
	gbm_result_if.source results
);
	import gbm_pkg::*;

	localparam int COEF_W = COEF_FRAC_BITS + 2;
	localparam int CNT_W = $clog2(MAX_BLOCK_LEN + 1);
	// energy accumulator: 2^F*(s1^2+s2^2) +- c*s1*s2 plus a sign bit
	localparam int Q_W = 2 * ACC_W + COEF_FRAC_BITS + 1;
	localparam int MB_W = Q_W - COEF_FRAC_BITS;
	localparam logic [Q_W-1:0] ROUND_C = Q_W'(1) << (COEF_FRAC_BITS - 1);
	localparam logic [MB_W-1:0] PROD_CLAMP = MB_W'(1) << PROD_CLAMP_LOG2;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCK_LEN);

	// block state
	logic signed [ACC_W-1:0]  s1_q, s2_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     ovf_q;
	logic [COEF_W-1:0]        coef_q;
	logic [COEF_W-1:0]        cmag_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic                     last_q;
	state_t                   state_q;

	// shared multiplier and its accumulator
	logic [DIGIT_W-1:0]       op_a, op_b;
	logic [2*DIGIT_W-1:0]     prod_c, prod_s1;
	mac_ctl_t                 mac_c, mac_s1;
	logic [Q_W-1:0]           acc_q, acc_sum, prod_sh;
	logic [3*DIGIT_W-1:0]     t_q;
	logic [STEP_W-1:0]        step_q;

	// shared compare-subtract for sqrt and divide
	logic [TW-1:0]            rad_q;
	logic [REM_W-1:0]         rem_q, lhs_c, rhs_c, diff_c;
	logic [RW-1:0]            root_q;
	logic                     borrow_c, ge_c;

	// output slot
	logic                     out_valid_q;
	logic [SAMPLE_BITS-1:0]   amp_q;
	logic                     sat_q;

	logic                     cfg_wr, in_beat, out_free;
	logic [ACC_W-1:0]         a1, a2;
	logic [2*DIGIT_W-1:0]     a1x, a2x;
	logic [DIGIT_W-1:0]       cmagx;
	logic                     prod_neg, cr_neg;
	logic [MB_W-1:0]          m_big;
	logic [M_W-1:0]           m_c;
	logic signed [S_W-1:0]    x_ext, s2_ext, m_ext, sum_c;
	logic                     fits_c;
	logic [ACC_W-1:0]         s0_c;
	logic [Q_W-1:0]           q_pos;
	logic [CNT_W-1:0]         n_c;
	logic                     amp_clip;

	// APB register: single writable coefficient, no wait states
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_TWO_COS_COEF);
	assign prdata = (paddr[2] == REG_TWO_COS_COEF) ?
		{{(32 - COEF_W){coef_q[COEF_W-1]}}, coef_q} : 32'd0;

	// a sample beat is taken when idle, or in the update cycle of a non-last sample
	assign samples.ready = (state_q == ST_IDLE) || ((state_q == ST_UPD) && !last_q);
	assign in_beat = samples.valid & samples.ready;

	assign results.valid = out_valid_q;
	assign results.bin_amplitude = amp_q;
	assign results.saturated = sat_q;
	assign out_free = !out_valid_q || results.ready;

	// magnitudes split into 32-bit digits
	assign a1 = s1_q[ACC_W-1] ? ACC_W'(-s1_q) : ACC_W'(s1_q);
	assign a2 = s2_q[ACC_W-1] ? ACC_W'(-s2_q) : ACC_W'(s2_q);
	assign a1x = {{(2 * DIGIT_W - ACC_W){1'b0}}, a1};
	assign a2x = {{(2 * DIGIT_W - ACC_W){1'b0}}, a2};
	assign cmagx = {{(DIGIT_W - COEF_W){1'b0}}, cmag_q};
	assign prod_neg = coef_q[COEF_W-1] ^ s1_q[ACC_W-1];
	assign cr_neg = prod_neg ^ s2_q[ACC_W-1];

	// operand select: recursion uses c*|s1|; the energy program runs
	// |s1|*|s2| into t, then |s1|^2+|s2|^2, then c*t
	always_comb begin
		op_a = '0;
		op_b = '0;
		mac_c = '0;
		unique case (state_q)
			ST_MUL0: begin
				op_a = cmagx;
				op_b = a1x[DIGIT_W-1:0];
				mac_c.valid = 1'b1;
			end
			ST_MUL1: begin
				op_a = cmagx;
				op_b = a1x[2*DIGIT_W-1:DIGIT_W];
				mac_c.valid = 1'b1;
				mac_c.shift = 2'd1;
			end
			ST_AMUL: begin
				mac_c.valid = 1'b1;
				case (step_q)
					STEP_W'(0): begin
						op_a = a1x[DIGIT_W-1:0];
						op_b = a2x[DIGIT_W-1:0];
					end
					STEP_W'(1): begin
						op_a = a1x[DIGIT_W-1:0];
						op_b = a2x[2*DIGIT_W-1:DIGIT_W];
						mac_c.shift = 2'd1;
					end
					STEP_W'(2): begin
						op_a = a1x[2*DIGIT_W-1:DIGIT_W];
						op_b = a2x[DIGIT_W-1:0];
						mac_c.shift = 2'd1;
					end
					STEP_W'(3): begin
						op_a = a1x[2*DIGIT_W-1:DIGIT_W];
						op_b = a2x[2*DIGIT_W-1:DIGIT_W];
						mac_c.shift = 2'd2;
					end
					STEP_W'(4): begin
						op_a = a1x[DIGIT_W-1:0];
						op_b = a1x[DIGIT_W-1:0];
					end
					STEP_W'(5), STEP_W'(6): begin
						op_a = a1x[DIGIT_W-1:0];
						op_b = a1x[2*DIGIT_W-1:DIGIT_W];
						mac_c.shift = 2'd1;
					end
					STEP_W'(7): begin
						op_a = a1x[2*DIGIT_W-1:DIGIT_W];
						op_b = a1x[2*DIGIT_W-1:DIGIT_W];
						mac_c.shift = 2'd2;
					end
					STEP_W'(8): begin
						op_a = a2x[DIGIT_W-1:0];
						op_b = a2x[DIGIT_W-1:0];
					end
					STEP_W'(9), STEP_W'(10): begin
						op_a = a2x[DIGIT_W-1:0];
						op_b = a2x[2*DIGIT_W-1:DIGIT_W];
						mac_c.shift = 2'd1;
					end
					STEP_W'(11): begin
						op_a = a2x[2*DIGIT_W-1:DIGIT_W];
						op_b = a2x[2*DIGIT_W-1:DIGIT_W];
						mac_c.shift = 2'd2;
					end
					STEP_W'(12): begin
						op_a = cmagx;
						op_b = t_q[DIGIT_W-1:0];
						mac_c.sub = !cr_neg;
					end
					STEP_W'(13): begin
						op_a = cmagx;
						op_b = t_q[2*DIGIT_W-1:DIGIT_W];
						mac_c.shift = 2'd1;
						mac_c.sub = !cr_neg;
					end
					STEP_W'(14): begin
						op_a = cmagx;
						op_b = t_q[3*DIGIT_W-1:2*DIGIT_W];
						mac_c.shift = 2'd2;
						mac_c.sub = !cr_neg;
					end
					default: begin
						mac_c.valid = 1'b0;
					end
				endcase
			end
			default: begin
				op_a = '0;
			end
		endcase
	end

	assign prod_c = op_a * op_b;

	// accumulate the registered partial product in the cycle after issue
	always_comb begin
		case (mac_s1.shift)
			2'd1: prod_sh = Q_W'(prod_s1) << DIGIT_W;
			2'd2: prod_sh = Q_W'(prod_s1) << (2 * DIGIT_W);
			default: prod_sh = Q_W'(prod_s1);
		endcase
		if (!mac_s1.valid) begin
			acc_sum = acc_q;
		end else if (mac_s1.sub) begin
			acc_sum = acc_q - prod_sh;
		end else begin
			acc_sum = acc_q + prod_sh;
		end
	end

	// recursion update: s0 = x + round(c*s1) - s2, saturated to 48 bits
	assign m_big = acc_q[Q_W-1:COEF_FRAC_BITS];
	assign m_c = (m_big > PROD_CLAMP) ? M_W'(PROD_CLAMP) : m_big[M_W-1:0];
	assign x_ext = {{(S_W - SAMPLE_BITS){x_q[SAMPLE_BITS-1]}}, x_q};
	assign s2_ext = {{(S_W - ACC_W){s2_q[ACC_W-1]}}, s2_q};
	assign m_ext = {{(S_W - M_W){1'b0}}, m_c};
	assign sum_c = x_ext + (prod_neg ? -m_ext : m_ext) - s2_ext;
	assign fits_c = (sum_c[S_W-1:ACC_W-1] == '0) || (sum_c[S_W-1:ACC_W-1] == '1);
	always_comb begin
		if (fits_c) begin
			s0_c = sum_c[ACC_W-1:0];
		end else if (sum_c[S_W-1]) begin
			s0_c = {1'b1, {(ACC_W - 1){1'b0}}};
		end else begin
			s0_c = {1'b0, {(ACC_W - 1){1'b1}}};
		end
	end

	// negative energy only from rounding-free exact arithmetic edge cases
	assign q_pos = acc_sum[Q_W-1] ? '0 : acc_sum;
	assign n_c = (cnt_q == '0) ? CNT_W'(1) : cnt_q;

	// one compare-subtract: restoring sqrt, then restoring divide by n
	always_comb begin
		if (state_q == ST_SQRT) begin
			lhs_c = {rem_q[REM_W-3:0], rad_q[TW-1:TW-2]};
			rhs_c = {{(REM_W - RW - 2){1'b0}}, root_q, 2'b01};
		end else begin
			lhs_c = {rem_q[REM_W-2:0], root_q[RW-1]};
			rhs_c = {{(REM_W - CNT_W){1'b0}}, n_c};
		end
		{borrow_c, diff_c} = {1'b0, lhs_c} - {1'b0, rhs_c};
		ge_c = !borrow_c;
	end

	assign amp_clip = |root_q[RW-1:SAMPLE_BITS];

	// multiplier pipeline register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1 <= '0;
		end else begin
			mac_s1 <= mac_c;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_c;
	end

	// coefficient register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
			cmag_q <= '0;
		end else if (cfg_wr) begin
			coef_q <= pwdata[COEF_W-1:0];
			cmag_q <= pwdata[COEF_W-1] ? -pwdata[COEF_W-1:0] : pwdata[COEF_W-1:0];
		end
	end

	// sequencer and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			s1_q <= '0;
			s2_q <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (results.valid && results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						state_q <= ST_MUL0;
					end
				end
				ST_MUL0: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_DRAIN;
				ST_DRAIN: state_q <= ST_UPD;
				ST_UPD: begin
					s1_q <= s0_c;
					s2_q <= s1_q;
					if (!fits_c) begin
						ovf_q <= 1'b1;
					end
					if (cnt_q < CNT_MAX) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end else begin
						ovf_q <= 1'b1;
					end
					if (last_q) begin
						state_q <= ST_AMUL;
					end else if (in_beat) begin
						state_q <= ST_MUL0;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_AMUL: begin
					if (step_q == STEP_T_LAST) begin
						state_q <= ST_TCPY;
					end else if (step_q == STEP_SQ_LAST) begin
						state_q <= ST_SHIFT;
					end else if (step_q == STEP_CR_LAST) begin
						state_q <= ST_QFIN;
					end
				end
				ST_TCPY: state_q <= ST_AMUL;
				ST_SHIFT: state_q <= ST_AMUL;
				ST_QFIN: state_q <= ST_SQRT;
				ST_SQRT: begin
					if (step_q == STEP_W'(RW - 1)) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (step_q == STEP_W'(RW - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						s1_q <= '0;
						s2_q <= '0;
						cnt_q <= '0;
						ovf_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		acc_q <= acc_sum;
		if (in_beat) begin
			x_q <= samples.sample;
			last_q <= samples.last_sample;
			// rounding constant for c*s1 goes in ahead of the products
			acc_q <= ROUND_C;
		end
		unique case (state_q)
			ST_UPD: begin
				if (last_q) begin
					acc_q <= '0;
					step_q <= '0;
				end
			end
			ST_AMUL: begin
				step_q <= step_q + STEP_W'(1);
			end
			ST_TCPY: begin
				t_q <= acc_sum[3*DIGIT_W-1:0];
				acc_q <= '0;
			end
			ST_SHIFT: begin
				acc_q <= acc_sum << COEF_FRAC_BITS;
			end
			ST_QFIN: begin
				// radicand = floor(4Q / 2^F)
				rad_q <= q_pos[Q_W-2 -: TW];
				rem_q <= '0;
				root_q <= '0;
				step_q <= '0;
			end
			ST_SQRT: begin
				rad_q <= rad_q << 2;
				rem_q <= ge_c ? diff_c : lhs_c;
				root_q <= {root_q[RW-2:0], ge_c};
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(RW - 1)) begin
					rem_q <= '0;
					step_q <= '0;
				end
			end
			ST_DIV: begin
				// dividend shifts out of root_q while the quotient shifts in
				rem_q <= ge_c ? diff_c : lhs_c;
				root_q <= {root_q[RW-2:0], ge_c};
				step_q <= step_q + STEP_W'(1);
			end
			ST_FIN: begin
				if (out_free) begin
					amp_q <= amp_clip ? '1 : root_q[SAMPLE_BITS-1:0];
					sat_q <= amp_clip | ovf_q;
				end
			end
			default: begin
				step_q <= step_q;
			end
		endcase
	end

endmodule

>>> verif/gbm_bin_check_pkg.sv
// Bin amplitude predictor and result scoreboard for the Goertzel core bench.
package gbm_bin_check_pkg;

	typedef logic [127:0] wide_t;

	localparam int     COEF_FRAC = 16;
	localparam int     MAX_BLOCK = 65536;
	localparam int     AMP_TOP   = 65535;
	localparam longint ACC_HI    = (longint'(1) << 47) - 1;
	localparam longint ACC_LO    = -ACC_HI - 1;

	typedef struct {
		logic [15:0] amp;
		logic        sat;
	} bin_result_t;

	class goertzel_bin_checker;
		longint      s_prev;
		longint      s_prev2;
		longint      coef;
		int unsigned block_len;
		bit          clip_seen;
		bin_result_t pending_bins[$];
		int          faults;
		int          beats;
		int          bins_seen;
		int          clipped_bins;

		function new();
			s_prev = 0;
			s_prev2 = 0;
			coef = 0;
			block_len = 0;
			clip_seen = 1'b0;
			faults = 0;
			beats = 0;
			bins_seen = 0;
			clipped_bins = 0;
		endfunction

		function void set_coef(logic [31:0] value);
			coef = longint'($signed(value[17:0]));
		endfunction

		function void flag(string msg);
			faults++;
			if (faults <= 10)
				$display("MISMATCH %s", msg);
		endfunction

		static function wide_t magw(longint v);
			return (v < 0) ? wide_t'(-v) : wide_t'(v);
		endfunction

		// c*s / 2^F, ties away from zero, magnitude clamped at 2^50
		function longint coef_product(longint s);
			wide_t p;
			p = (magw(coef) * magw(s) + (wide_t'(1) << (COEF_FRAC - 1))) >> COEF_FRAC;
			if (p > (wide_t'(1) << 50))
				p = wide_t'(1) << 50;
			return ((coef < 0) != (s < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
		endfunction

		// largest A with (A*n)^2 * 2^F <= 4*Q, searched up to one past full scale
		function int unsigned amplitude_floor();
			wide_t       a1, a2, sq, cr, q, lim, an;
			int unsigned lo, hi, mid, n;
			a1 = magw(s_prev);
			a2 = magw(s_prev2);
			n = (block_len != 0) ? block_len : 1;
			sq = (a1 * a1 + a2 * a2) << COEF_FRAC;
			cr = magw(coef) * a1 * a2;
			if ((coef < 0) ^ (s_prev < 0) ^ (s_prev2 < 0))
				q = sq + cr;
			else if (sq >= cr)
				q = sq - cr;
			else
				q = '0;
			lim = q << 2;
			lo = 0;
			hi = AMP_TOP + 1;
			while (lo < hi) begin
				mid = (lo + hi + 1) / 2;
				an = wide_t'(mid) * wide_t'(n);
				if (((an * an) << COEF_FRAC) <= lim)
					lo = mid;
				else
					hi = mid - 1;
			end
			return lo;
		endfunction

		function void take_sample(logic signed [15:0] x, logic lst);
			longint      s0;
			int unsigned lo;
			bin_result_t r;
			beats++;
			s0 = longint'(x) + coef_product(s_prev) - s_prev2;
			if (s0 > ACC_HI) begin
				s0 = ACC_HI;
				clip_seen = 1'b1;
			end
			if (s0 < ACC_LO) begin
				s0 = ACC_LO;
				clip_seen = 1'b1;
			end
			s_prev2 = s_prev;
			s_prev = s0;
			if (block_len < MAX_BLOCK)
				block_len++;
			else
				clip_seen = 1'b1;
			if (lst) begin
				lo = amplitude_floor();
				r.amp = (lo > AMP_TOP) ? 16'hFFFF : lo[15:0];
				r.sat = (lo > AMP_TOP) || clip_seen;
				pending_bins.push_back(r);
				s_prev = 0;
				s_prev2 = 0;
				block_len = 0;
				clip_seen = 1'b0;
			end
		endfunction

		function void check_result(logic [15:0] amp, logic sat);
			bin_result_t want;
			bins_seen++;
			if (sat === 1'b1)
				clipped_bins++;
			if (pending_bins.size() == 0) begin
				flag($sformatf("unexpected bin result %0d: amp=%0d sat=%b",
					bins_seen, amp, sat));
				return;
			end
			want = pending_bins.pop_front();
			if (amp !== want.amp)
				flag($sformatf("bin %0d amplitude: want %0d got %0d",
					bins_seen, want.amp, amp));
			if (sat !== want.sat)
				flag($sformatf("bin %0d saturated: want %b got %b",
					bins_seen, want.sat, sat));
		endfunction
	endclass

endpackage

>>> verif/tb_goertzel_bin_magnitude_core.sv
// Top-level bench for the Goertzel bin magnitude core: stimulus, APB setup, checks.
module tb_goertzel_bin_magnitude_core;
	timeunit 1ns;
	timeprecision 1ps;

	import gbm_pkg::*;
	import gbm_bin_check_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int SETTLE_CYCLES = 140;   // covers the last-sample latency
	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam int PHASE_BEATS   = 300;
	localparam int LONG_BLOCK    = 96000; // past the count clamp and into acc clipping
	localparam int HOLD_CYCLES   = 400;

	// register map: index 0 at byte 0, the other index decode is a dead slot
	localparam logic [2:0]  COEF_ADDR   = {REG_TWO_COS_COEF, 2'b00};
	localparam logic [2:0]  GHOST_ADDR  = {~REG_TWO_COS_COEF, 2'b00};
	// Q2.16 extremes: just under +2.0, and -2.0 (upper bits zero to test sign extension)
	localparam logic [31:0] COEF_TOP    = 32'h0001_FFFF;
	localparam logic [31:0] COEF_BOTTOM = 32'h0002_0000;

	typedef enum int {BK_NOISE, BK_RAILS, BK_QUIET, BK_TONE} block_kind_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	gbm_sample_if #(.SAMPLE_BITS(16)) sample_ch ();
	gbm_result_if #(.SAMPLE_BITS(16)) result_ch ();

	goertzel_bin_checker chk;

	// calm: no idling on either side; hold_left: receiver backpressure stretch
	bit calm = 1'b0;
	int hold_left = 0;
	int coef_writes = 0;
	int cycles = 0;

	goertzel_bin_magnitude_core #(
		.MAX_BLOCK_LEN(65536),
		.SAMPLE_BITS(16),
		.COEF_FRAC_BITS(16)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.samples(sample_ch),
		.results(result_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// APB write: setup beat, then access; the register takes it at the access edge
	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// read the coefficient back; only its 18 bits are compared
	task automatic confirm_coef();
		logic [31:0] got;
		longint      want;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= COEF_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		want = chk.coef;
		if (got[17:0] !== want[17:0])
			chk.flag($sformatf("coef readback: want %h got %h", want[17:0], got[17:0]));
	endtask

	// drop valid, drain every pending bin, then cover any trailing recursion
	task automatic settle();
		sample_ch.valid <= 1'b0;
		while (chk.pending_bins.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_coef(input logic [31:0] value);
		settle();
		apb_write(COEF_ADDR, value);
		chk.set_coef(value);
		coef_writes++;
		confirm_coef();
	endtask

	// one sample beat; called right after an edge, returns at its acceptance edge.
	// With no gap, valid stays high and only the payload moves.
	task automatic send_beat(input logic signed [15:0] x, input logic lst);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.sample <= x;
		sample_ch.last_sample <= lst;
		do @(posedge clk); while (!sample_ch.ready);
		chk.take_sample(x, lst);
	endtask

	// a block of len beats, closed by a last beat
	task automatic send_block(input int len, input block_kind_t kind);
		logic signed [15:0] x;
		logic signed [15:0] tone_amp;
		bit                 flip;
		tone_amp = $urandom();
		flip = $urandom_range(0, 1);
		for (int i = 0; i < len; i++) begin
			case (kind)
				BK_NOISE: x = $urandom();
				BK_RAILS: x = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
				BK_QUIET: x = 16'($urandom_range(0, 16) - 8);
				// DC or Nyquist tone, the resonant cases for c near +2 / -2
				default:  x = (flip && i[0]) ? -tone_amp : tone_amp;
			endcase
			send_beat(x, i == len - 1);
		end
	endtask

	// mostly short blocks, now and then a longer one; calm stretches mixed in
	task automatic run_phase(input int budget);
		int sent;
		int len;
		sent = 0;
		while (sent < budget) begin
			calm = ($urandom_range(0, 3) == 0);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 200) : $urandom_range(1, 16);
			send_block(len, block_kind_t'($urandom_range(0, 3)));
			sent += len;
		end
		calm = 1'b0;
	endtask

	// result side: samples the beat before the edge updates, then draws the next wait
	initial begin : result_sink
		int rx_wait;
		rx_wait = 0;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				chk.check_result(result_ch.bin_amplitude, result_ch.saturated);
				rx_wait = calm ? 0 : $urandom_range(0, 12);
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d bins still pending",
			cycles, chk.pending_bins.size());
		$display("tb_goertzel_bin_magnitude_core: errors");
		$finish;
	end

	initial begin : stimulus
		logic [31:0] phase_coefs [6];
		chk = new();
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		sample_ch.valid <= 1'b0;
		sample_ch.sample <= '0;
		sample_ch.last_sample <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed: coefficient still at its reset value of zero
		// one-sample blocks: full positive, full negative (amplitude clips), zero
		send_beat(16'sh7FFF, 1'b1);
		send_beat(16'sh8000, 1'b1);
		send_beat(16'sh0000, 1'b1);
		send_beat(16'sh7FFF, 1'b0);
		send_beat(16'sh8000, 1'b0);
		send_beat(16'sh7FFF, 1'b0);
		send_beat(16'sh8000, 1'b1);
		send_beat(16'sh0001, 1'b0);
		send_beat(-16'sh0001, 1'b1);

		// write to the unmapped slot must leave the coefficient alone
		settle();
		apb_write(GHOST_ADDR, $urandom());
		confirm_coef();

		// c = -2.0 with a Nyquist tone: quadratic growth
		load_coef(COEF_BOTTOM);
		for (int i = 0; i < 6; i++)
			send_beat(i[0] ? -16'sh7FFF : 16'sh7FFF, i == 5);

		// c just under +2.0 with full-scale DC
		load_coef(COEF_TOP);
		for (int i = 0; i < 8; i++)
			send_beat(16'sh7FFF, i == 7);

		// --- random phases over several coefficient settings
		phase_coefs[0] = COEF_TOP;
		phase_coefs[1] = COEF_BOTTOM;
		phase_coefs[2] = $urandom();
		phase_coefs[3] = $urandom();
		phase_coefs[4] = $urandom();
		phase_coefs[5] = $urandom();
		for (int p = 0; p < 6; p++) begin
			load_coef(phase_coefs[p]);
			if (p == 3) begin
				// receiver goes dark while short blocks keep coming at full rate,
				// so the output slot fills and the sample input backs up
				calm = 1'b1;
				hold_left = HOLD_CYCLES;
				repeat (40) send_block($urandom_range(1, 2), BK_NOISE);
				calm = 1'b0;
			end
			run_phase(PHASE_BEATS);
		end

		// --- one very long block at c = -2.0: sample count pins at the maximum,
		// then the accumulators hit their clip
		load_coef(COEF_BOTTOM);
		calm = 1'b1;
		for (int i = 0; i < LONG_BLOCK; i++)
			send_beat(i[0] ? -16'sh7FFF : 16'sh7FFF, i == LONG_BLOCK - 1);
		calm = 1'b0;

		settle();
		$display("covered %0d sample beats over %0d coefficient loads, longest block %0d beats",
			chk.beats, coef_writes, LONG_BLOCK);
		$display("checked %0d bin results (%0d saturated), %0d mismatches",
			chk.bins_seen, chk.clipped_bins, chk.faults);
		if (chk.faults == 0)
			$display("tb_goertzel_bin_magnitude_core: clean");
		else
			$display("tb_goertzel_bin_magnitude_core: errors");
		$finish;
	end

endmodule

>>> goertzel_bin_magnitude_core.f
design/gbm_pkg.sv
design/gbm_ifs.sv
design/goertzel_bin_magnitude_core.sv
verif/gbm_bin_check_pkg.sv
verif/tb_goertzel_bin_magnitude_core.sv
